### rtl/slm_pkg.sv
`timescale 1ns / 1ps
package slm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int EPS_W   = 32;
    localparam int GAP_W   = 31;
    localparam int CFG_IW  = 1;
    localparam int CFG_DW  = 32;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;
    localparam logic [GAP_W-1:0] GAP_RESET = 31'd65536;

    localparam logic [CFG_IW-1:0] REG_EPS = 1'b0;
    localparam logic [CFG_IW-1:0] REG_GAP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_FAR      = 2'd2
    } status_t;

endpackage

### rtl/slm_if.sv
`timescale 1ns / 1ps
interface slm_pair_if import slm_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] first_origin_x;
    logic signed [CW-1:0] first_origin_y;
    logic signed [CW-1:0] first_origin_z;
    logic signed [CW-1:0] first_dir_x;
    logic signed [CW-1:0] first_dir_y;
    logic signed [CW-1:0] first_dir_z;
    logic signed [CW-1:0] second_origin_x;
    logic signed [CW-1:0] second_origin_y;
    logic signed [CW-1:0] second_origin_z;
    logic signed [CW-1:0] second_dir_x;
    logic signed [CW-1:0] second_dir_y;
    logic signed [CW-1:0] second_dir_z;

    modport source (
        output valid, first_origin_x, first_origin_y, first_origin_z,
               first_dir_x, first_dir_y, first_dir_z,
               second_origin_x, second_origin_y, second_origin_z,
               second_dir_x, second_dir_y, second_dir_z,
        input  ready
    );
    modport sink (
        input  valid, first_origin_x, first_origin_y, first_origin_z,
               first_dir_x, first_dir_y, first_dir_z,
               second_origin_x, second_origin_y, second_origin_z,
               second_dir_x, second_dir_y, second_dir_z,
        output ready
    );
endinterface

interface slm_result_if import slm_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [1:0]           status;

    modport source (output valid, point_x, point_y, point_z, status, input ready);
    modport sink (input valid, point_x, point_y, point_z, status, output ready);
endinterface

interface slm_cfg_if import slm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/slm_dly.sv
`timescale 1ns / 1ps
module slm_dly #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    generate
        if (D == 0) begin : g_none
            assign q = d;
        end
        else begin : g_line
            logic [W-1:0] tap_reg [D];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tap_reg[0] <= d;
                    for (int k = 1; k < D; k++)
                    begin
                        tap_reg[k] <= tap_reg[k-1];
                    end
                end
            end
            assign q = tap_reg[D-1];
        end
    endgenerate
endmodule

### rtl/slm_mul.sv
`timescale 1ns / 1ps
module slm_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    // sign-magnitude, one 32x32 limb product per stage
    localparam int PW  = AW + BW;
    localparam int NA  = (AW + 31) / 32;
    localparam int NB  = (BW + 31) / 32;
    localparam int NS  = NA * NB;
    localparam int AXW = NA * 32;
    localparam int BXW = NB * 32;
    localparam int XW  = AXW + BXW;

    logic [AW-1:0]  a_mag;
    logic [BW-1:0]  b_mag;
    logic [AXW-1:0] am_reg  [NS];
    logic [BXW-1:0] bm_reg  [NS];
    logic           sg_reg  [NS+1];
    logic [XW-1:0]  acc_reg [NS+1];
    logic [PW-1:0]  p_reg;

    assign a_mag = a[AW-1] ? AW'(-a) : AW'(a);
    assign b_mag = b[BW-1] ? BW'(-b) : BW'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg[0]  <= AXW'(a_mag);
            bm_reg[0]  <= BXW'(b_mag);
            sg_reg[0]  <= a[AW-1] ^ b[BW-1];
            acc_reg[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_limb
            logic [63:0] part;
            assign part = 64'(am_reg[k][32 * (k / NB) +: 32]) *
                          64'(bm_reg[k][32 * (k % NB) +: 32]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    acc_reg[k+1] <= acc_reg[k] + (XW'(part) << (32 * (k / NB + k % NB)));
                    sg_reg[k+1]  <= sg_reg[k];
                end
            end
            if (k + 1 < NS) begin : g_pass
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        am_reg[k+1] <= am_reg[k];
                        bm_reg[k+1] <= bm_reg[k];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sg_reg[NS] ? -PW'(acc_reg[NS]) : PW'(acc_reg[NS]);
        end
    end

    assign p = p_reg;
endmodule

### rtl/slm_div.sv
`timescale 1ns / 1ps
module slm_div #(
    parameter int CW = 32,
    parameter int GW = 164,
    parameter int DW = 129
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [GW-1:0] n,
    input  logic signed [DW-1:0] den,
    output logic signed [CW-1:0] q
);
    // round(n / 2den) as floor((|n|+|den|) / 2|den|), saturated
    localparam int RW = (GW + 1 > DW + 1 + CW) ? GW + 1 : DW + 1 + CW;
    localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};

    logic [GW-1:0] an_reg;
    logic [DW-1:0] ad_reg;
    logic          neg1_reg;
    logic [RW-1:0] num_reg;
    logic [DW:0]   dd_reg;
    logic          neg2_reg;

    logic [RW-1:0] rem_reg  [CW];
    logic [DW:0]   dd_s_reg [CW];
    logic [CW-1:0] qb_reg   [CW+1];
    logic          huge_reg [CW+1];
    logic          neg_reg  [CW+1];
    logic [CW-1:0] q_reg;
    logic [CW-1:0] q_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg   <= n[GW-1] ? GW'(-n) : GW'(n);
            ad_reg   <= den[DW-1] ? DW'(-den) : DW'(den);
            neg1_reg <= n[GW-1] ^ den[DW-1];
            num_reg  <= RW'(an_reg) + RW'(ad_reg);
            dd_reg   <= {ad_reg, 1'b0};
            neg2_reg <= neg1_reg;
            rem_reg[0]  <= num_reg;
            dd_s_reg[0] <= dd_reg;
            qb_reg[0]   <= '0;
            huge_reg[0] <= num_reg >= (RW'(dd_reg) << CW);
            neg_reg[0]  <= neg2_reg;
        end
    end

    genvar k;
    generate
        for (k = 0; k < CW; k++) begin : g_step
            logic [RW-1:0] sh;
            logic          ge;
            assign sh = RW'(dd_s_reg[k]) << (CW - 1 - k);
            assign ge = rem_reg[k] >= sh;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    qb_reg[k+1]   <= qb_reg[k] | (CW'(ge) << (CW - 1 - k));
                    huge_reg[k+1] <= huge_reg[k];
                    neg_reg[k+1]  <= neg_reg[k];
                end
            end
            if (k + 1 < CW) begin : g_pass
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k+1]  <= ge ? rem_reg[k] - sh : rem_reg[k];
                        dd_s_reg[k+1] <= dd_s_reg[k];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (neg_reg[CW])
        begin
            if (huge_reg[CW] || (qb_reg[CW][CW-1] && (qb_reg[CW] != HALF)))
                q_next = HALF;
            else
                q_next = -qb_reg[CW];
        end
        else
        begin
            if (huge_reg[CW] || qb_reg[CW][CW-1])
                q_next = ~HALF;
            else
                q_next = qb_reg[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;
endmodule

### rtl/skew_line_midpoint_triangulator_core.sv
`timescale 1ns / 1ps
// Path from input transfer to result valid: stage 0, three limb multiplier groups,
// gap-test squaring and compare, output (the CW-step divider runs alongside and is
// padded to match).
// Throughput: one line pair per cycle; the global stall lifts while the skid stage is empty.
// Reset: valid bits and skid/output flags clear, the config registers take their reset values.
// No clearing pass; the block accepts a transfer on the first cycle after reset.
module skew_line_midpoint_triangulator_core import slm_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    slm_pair_if.sink     pair,
    slm_result_if.source result,
    slm_cfg_if.sink      cfg
);
    localparam int CW   = COORD_WIDTH;
    localparam int XW   = CW + 1;
    localparam int DTW  = 2 * CW + 2;
    localparam int DW   = 4 * CW + 1;
    localparam int NW   = 4 * CW + 3;
    localparam int GW   = 5 * CW + 4;
    localparam int MGW  = 4 * CW + 33;
    localparam int AW3  = (XW > 32) ? XW : 32;
    localparam int AW4  = (GW > MGW) ? GW : MGW;
    localparam int SQW  = 2 * AW4 + 2;
    localparam int EW   = (DW > EPS_W + 2 * FRAC_BITS) ? DW : EPS_W + 2 * FRAC_BITS;
    localparam int NL1  = ((CW + 31) / 32) * ((XW + 31) / 32);
    localparam int NL2  = ((DTW + 31) / 32) * ((DTW + 31) / 32);
    localparam int NL3  = ((AW3 + 31) / 32) * ((NW + 31) / 32);
    localparam int NL4  = ((AW4 + 31) / 32) * ((AW4 + 31) / 32);
    localparam int L1   = NL1 + 2;
    localparam int L2   = NL2 + 2;
    localparam int L3   = NL3 + 2;
    localparam int L4   = NL4 + 2;
    localparam int LD   = CW + 4;
    localparam int LG   = L4 + 2;
    localparam int LT   = (LD > LG) ? LD : LG;
    localparam int I3   = L1 + L2 + 2;
    localparam int I4   = I3 + L3 + 1;
    localparam int E    = I4 + LT;
    localparam int GDLY = LT - LG;
    localparam int QDLY = LT - LD;
    localparam int SW   = 6 * CW + 6 * XW;
    localparam int RESW = 3 * CW + 2;

    // configuration
    logic [EPS_W-1:0] eps_reg;
    logic [GAP_W-1:0] max_gap_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg     <= EPS_RESET;
            max_gap_reg <= GAP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_EPS: eps_reg     <= cfg.data[EPS_W-1:0];
                REG_GAP: max_gap_reg <= cfg.data[GAP_W-1:0];
            endcase
        end
    end

    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic [E:0] vld_reg;

    assign en         = !skid_valid_reg;
    assign pair.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[E-1:0], pair.valid};
    end

    // stage 0: y/z swap on directions, origin difference and sum
    logic signed [CW-1:0] d1_reg [3];
    logic signed [CW-1:0] d2_reg [3];
    logic signed [XW-1:0] w0_reg [3];
    logic signed [XW-1:0] sp_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg[0] <= pair.first_dir_x;
            d1_reg[1] <= pair.first_dir_z;
            d1_reg[2] <= pair.first_dir_y;
            d2_reg[0] <= pair.second_dir_x;
            d2_reg[1] <= pair.second_dir_z;
            d2_reg[2] <= pair.second_dir_y;
            w0_reg[0] <= XW'(pair.first_origin_x) - XW'(pair.second_origin_x);
            w0_reg[1] <= XW'(pair.first_origin_y) - XW'(pair.second_origin_y);
            w0_reg[2] <= XW'(pair.first_origin_z) - XW'(pair.second_origin_z);
            sp_reg[0] <= XW'(pair.first_origin_x) + XW'(pair.second_origin_x);
            sp_reg[1] <= XW'(pair.first_origin_y) + XW'(pair.second_origin_y);
            sp_reg[2] <= XW'(pair.first_origin_z) + XW'(pair.second_origin_z);
        end
    end

    // dot products
    logic signed [2*CW:0] pa [3];
    logic signed [2*CW:0] pb [3];
    logic signed [2*CW:0] pc [3];
    logic signed [2*CW:0] pd [3];
    logic signed [2*CW:0] pe [3];

    genvar i;
    generate
        for (i = 0; i < 3; i++) begin : g_dot
            slm_mul #(.AW(CW), .BW(XW)) u_aa (
                .clk(clk), .en(en), .a(d1_reg[i]), .b(XW'(d1_reg[i])), .p(pa[i]));
            slm_mul #(.AW(CW), .BW(XW)) u_ab (
                .clk(clk), .en(en), .a(d1_reg[i]), .b(XW'(d2_reg[i])), .p(pb[i]));
            slm_mul #(.AW(CW), .BW(XW)) u_bb (
                .clk(clk), .en(en), .a(d2_reg[i]), .b(XW'(d2_reg[i])), .p(pc[i]));
            slm_mul #(.AW(CW), .BW(XW)) u_aw (
                .clk(clk), .en(en), .a(d1_reg[i]), .b(w0_reg[i]), .p(pd[i]));
            slm_mul #(.AW(CW), .BW(XW)) u_bw (
                .clk(clk), .en(en), .a(d2_reg[i]), .b(w0_reg[i]), .p(pe[i]));
        end
    endgenerate

    logic signed [DTW-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= DTW'(pa[0]) + DTW'(pa[1]) + DTW'(pa[2]);
            b_reg <= DTW'(pb[0]) + DTW'(pb[1]) + DTW'(pb[2]);
            c_reg <= DTW'(pc[0]) + DTW'(pc[1]) + DTW'(pc[2]);
            d_reg <= DTW'(pd[0]) + DTW'(pd[1]) + DTW'(pd[2]);
            e_reg <= DTW'(pe[0]) + DTW'(pe[1]) + DTW'(pe[2]);
        end
    end

    // denominator and line parameter numerators
    logic signed [2*DTW-1:0] p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

    slm_mul #(.AW(DTW), .BW(DTW)) u_ac (
        .clk(clk), .en(en), .a(a_reg), .b(c_reg), .p(p_ac));
    slm_mul #(.AW(DTW), .BW(DTW)) u_bb (
        .clk(clk), .en(en), .a(b_reg), .b(b_reg), .p(p_bb));
    slm_mul #(.AW(DTW), .BW(DTW)) u_be (
        .clk(clk), .en(en), .a(b_reg), .b(e_reg), .p(p_be));
    slm_mul #(.AW(DTW), .BW(DTW)) u_cd (
        .clk(clk), .en(en), .a(c_reg), .b(d_reg), .p(p_cd));
    slm_mul #(.AW(DTW), .BW(DTW)) u_ae (
        .clk(clk), .en(en), .a(a_reg), .b(e_reg), .p(p_ae));
    slm_mul #(.AW(DTW), .BW(DTW)) u_bd (
        .clk(clk), .en(en), .a(b_reg), .b(d_reg), .p(p_bd));

    logic signed [DW-1:0] den_reg;
    logic signed [NW-1:0] nt_reg, ns_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= DW'(p_ac - p_bb);
            nt_reg  <= NW'(p_be - p_cd);
            ns_reg  <= NW'(p_ae - p_bd);
        end
    end

    // stage-0 operands carried to the third multiplier group
    logic [SW-1:0] side_in, side_out;
    logic signed [CW-1:0] d1_d [3];
    logic signed [CW-1:0] d2_d [3];
    logic signed [XW-1:0] w0_d [3];
    logic signed [XW-1:0] sp_d [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            side_in[k*CW +: CW]               = d1_reg[k];
            side_in[(3+k)*CW +: CW]           = d2_reg[k];
            side_in[6*CW + k*XW +: XW]        = w0_reg[k];
            side_in[6*CW + (3+k)*XW +: XW]    = sp_reg[k];
            d1_d[k] = side_out[k*CW +: CW];
            d2_d[k] = side_out[(3+k)*CW +: CW];
            w0_d[k] = side_out[6*CW + k*XW +: XW];
            sp_d[k] = side_out[6*CW + (3+k)*XW +: XW];
        end
    end

    slm_dly #(.W(SW), .D(I3)) u_side (.clk(clk), .en(en), .d(side_in), .q(side_out));

    // parallel test
    logic [DW-1:0] den_abs;
    logic          par_now;
    logic          par_i4;
    logic signed [DW-1:0] den_i4;

    assign den_abs = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
    assign par_now = (den_reg == '0) ||
                     (EW'(den_abs) < (EW'(eps_reg) << (2 * FRAC_BITS)));

    slm_dly #(.W(DW+1), .D(L3+1)) u_den_dly (
        .clk(clk), .en(en), .d({par_now, den_reg}), .q({par_i4, den_i4}));

    // nearest point terms
    logic signed [AW3+NW-1:0] p_dw [3];
    logic signed [AW3+NW-1:0] p_nd [3];
    logic signed [AW3+NW-1:0] p_sd [3];
    logic signed [AW3+NW-1:0] p_ds [3];
    logic signed [AW3+NW-1:0] p_mg;

    generate
        for (i = 0; i < 3; i++) begin : g_term
            slm_mul #(.AW(AW3), .BW(NW)) u_dw (
                .clk(clk), .en(en), .a(AW3'(w0_d[i])), .b(NW'(den_reg)), .p(p_dw[i]));
            slm_mul #(.AW(AW3), .BW(NW)) u_nd (
                .clk(clk), .en(en), .a(AW3'(d1_d[i])), .b(nt_reg), .p(p_nd[i]));
            slm_mul #(.AW(AW3), .BW(NW)) u_sd (
                .clk(clk), .en(en), .a(AW3'(d2_d[i])), .b(ns_reg), .p(p_sd[i]));
            slm_mul #(.AW(AW3), .BW(NW)) u_ds (
                .clk(clk), .en(en), .a(AW3'(sp_d[i])), .b(NW'(den_reg)), .p(p_ds[i]));
        end
    endgenerate

    slm_mul #(.AW(AW3), .BW(NW)) u_mg (
        .clk(clk), .en(en), .a(AW3'(signed'({1'b0, max_gap_reg}))), .b(NW'(den_reg)),
        .p(p_mg));

    logic signed [GW-1:0]  g_reg [3];
    logic signed [GW-1:0]  n_reg [3];
    logic signed [MGW-1:0] mgd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                g_reg[k] <= GW'(p_dw[k]) + GW'(p_nd[k]) - GW'(p_sd[k]);
                n_reg[k] <= GW'(p_ds[k]) + GW'(p_nd[k]) + GW'(p_sd[k]);
            end
            mgd_reg <= MGW'(p_mg);
        end
    end

    // gap test, scaled by den squared
    logic signed [2*AW4-1:0] sq_g [3];
    logic signed [2*AW4-1:0] sq_m;

    generate
        for (i = 0; i < 3; i++) begin : g_sq
            slm_mul #(.AW(AW4), .BW(AW4)) u_sq (
                .clk(clk), .en(en), .a(AW4'(g_reg[i])), .b(AW4'(g_reg[i])), .p(sq_g[i]));
        end
    endgenerate

    slm_mul #(.AW(AW4), .BW(AW4)) u_sqm (
        .clk(clk), .en(en), .a(AW4'(mgd_reg)), .b(AW4'(mgd_reg)), .p(sq_m));

    logic [SQW-1:0] sum_reg, lim_reg;
    logic           far_reg;
    logic           far_e;
    logic           par_e;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= SQW'(sq_g[0]) + SQW'(sq_g[1]) + SQW'(sq_g[2]);
            lim_reg <= SQW'(sq_m);
            far_reg <= sum_reg > lim_reg;
        end
    end

    slm_dly #(.W(1), .D(GDLY)) u_far_dly (.clk(clk), .en(en), .d(far_reg), .q(far_e));
    slm_dly #(.W(1), .D(LT)) u_par_dly (.clk(clk), .en(en), .d(par_i4), .q(par_e));

    // midpoint division
    logic signed [CW-1:0] q_d [3];
    logic signed [CW-1:0] q_e [3];

    generate
        for (i = 0; i < 3; i++) begin : g_div
            slm_div #(.CW(CW), .GW(GW), .DW(DW)) u_div (
                .clk(clk), .en(en), .n(n_reg[i]), .den(den_i4), .q(q_d[i]));
            slm_dly #(.W(CW), .D(QDLY)) u_q_dly (
                .clk(clk), .en(en), .d(q_d[i]), .q(q_e[i]));
        end
    endgenerate

    // result and skid stage
    status_t         st_e;
    logic [RESW-1:0] res_next;
    logic [RESW-1:0] out_reg;
    logic [RESW-1:0] skid_reg;
    logic            push;

    always_comb
    begin
        priority if (par_e)
            st_e = ST_PARALLEL;
        else if (far_e)
            st_e = ST_FAR;
        else
            st_e = ST_OK;
        if (st_e == ST_OK)
            res_next = {st_e, q_e[0], q_e[1], q_e[2]};
        else
            res_next = {st_e, {(3*CW){1'b0}}};
    end

    assign push = vld_reg[E] && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
            out_reg <= skid_valid_reg ? skid_reg : res_next;
        else if (push)
            skid_reg <= res_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.status  = out_reg[RESW-1 -: 2];
    assign result.point_x = out_reg[3*CW-1 -: CW];
    assign result.point_y = out_reg[2*CW-1 -: CW];
    assign result.point_z = out_reg[CW-1:0];
endmodule

### rtl/slm_chk.sv
`timescale 1ns / 1ps
module slm_chk import slm_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [CW-1:0] px,
    input logic [CW-1:0] py,
    input logic [CW-1:0] pz,
    input logic [1:0]    status
);
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (px == '0) && (py == '0) && (pz == '0))
        else $error("failed result carries a nonzero point");

    a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({px, py, pz, status}))
        else $error("result changed while stalled");
endmodule

bind skew_line_midpoint_triangulator_core slm_chk #(.CW(COORD_WIDTH)) u_slm_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(pair.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .px(result.point_x),
    .py(result.point_y),
    .pz(result.point_z),
    .status(result.status)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import slm_pkg::*;

    typedef logic signed [31:0]  coord_t;
    typedef logic signed [511:0] wide_t;
    typedef coord_t              pair_t [12];

    typedef struct {
        coord_t  x;
        coord_t  y;
        coord_t  z;
        status_t st;
    } point_t;

    localparam int LATENCY = 71;

    logic clk;
    logic rst_n;

    slm_pair_if   pair_ch ();
    slm_result_if res_ch ();
    slm_cfg_if    cfg_ch ();

    skew_line_midpoint_triangulator_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    logic [EPS_W-1:0] eps_reg;
    logic [GAP_W-1:0] gap_reg;

    pair_t  pending_pairs [$];
    point_t expected_points [$];
    int     mismatches;
    bit     calm;
    bit     pair_taken;
    bit     point_taken;
    int     send_hold;
    int     recv_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    // exact triangulation, rounding half away from zero, saturated
    function automatic point_t triangulate(pair_t p);
        wide_t  o1[3], o2[3], u1[3], u2[3], w[3];
        wide_t  a, b, c, d, e, den, nt, ns, aden, g, gsum, lim, n, an, q;
        coord_t mid[3];
        bit     neg;
        point_t r;
        for (int i = 0; i < 3; i++)
        begin
            o1[i] = p[i];
            o2[i] = p[6 + i];
            w[i]  = o1[i] - o2[i];
        end
        u1[0] = p[3]; u1[1] = p[5]; u1[2] = p[4];
        u2[0] = p[9]; u2[1] = p[11]; u2[2] = p[10];
        a = 0; b = 0; c = 0; d = 0; e = 0;
        for (int i = 0; i < 3; i++)
        begin
            a += u1[i] * u1[i];
            b += u1[i] * u2[i];
            c += u2[i] * u2[i];
            d += u1[i] * w[i];
            e += u2[i] * w[i];
        end
        den  = a * c - b * b;
        nt   = b * e - c * d;
        ns   = a * e - b * d;
        aden = den < 0 ? -den : den;
        r.x = 0; r.y = 0; r.z = 0;
        if (den == 0 || aden < {448'b0, eps_reg, 32'b0})
        begin
            r.st = ST_PARALLEL;
            return r;
        end
        gsum = 0;
        for (int i = 0; i < 3; i++)
        begin
            g = den * w[i] + nt * u1[i] - ns * u2[i];
            gsum += g * g;
        end
        lim = {481'b0, gap_reg};
        lim = lim * lim * den * den;
        if (gsum > lim)
        begin
            r.st = ST_FAR;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            n   = den * (o1[i] + o2[i]) + nt * u1[i] + ns * u2[i];
            neg = n[511] ^ den[511];
            an  = n < 0 ? -n : n;
            q   = (an + aden) / (2 * aden);
            if (neg)
                mid[i] = (q > 64'sd2147483648) ? 32'sh8000_0000 : coord_t'(-q);
            else
                mid[i] = (q > 64'sd2147483647) ? 32'sh7FFF_FFFF : coord_t'(q);
        end
        r.x = mid[0]; r.y = mid[1]; r.z = mid[2];
        r.st = ST_OK;
        return r;
    endfunction

    function automatic int span(int lim_v);
        return int'($urandom_range(0, 2 * lim_v)) - lim_v;
    endfunction

    // lines built in swapped space through a common point; the parallel flag makes them parallel
    function automatic pair_t crossing(int spread, int dspread, int noise, bit parallel);
        int    pt[3], d1[3], d2[3];
        int    t1, t2, k;
        pair_t r;
        t1 = span(8);
        t2 = span(8);
        k  = int'($urandom_range(1, 3)) * ($urandom_range(0, 1) ? 1 : -1);
        for (int i = 0; i < 3; i++)
        begin
            pt[i] = span(spread);
            d1[i] = span(dspread);
            d2[i] = parallel ? k * d1[i] : span(dspread);
            r[i]     = pt[i] + t1 * d1[i] + span(noise);
            r[6 + i] = pt[i] + t2 * d2[i] + span(noise);
        end
        r[3] = d1[0]; r[4] = d1[2]; r[5] = d1[1];
        r[9] = d2[0]; r[10] = d2[2]; r[11] = d2[1];
        return r;
    endfunction

    function automatic pair_t random_pair(int mode);
        pair_t r;
        case (mode)
            0:
                for (int i = 0; i < 12; i++) r[i] = $urandom;
            1:
                for (int i = 0; i < 12; i++) r[i] = span(1 << 20);
            2:
                r = crossing(1 << 22, 1 << 17, 0, 1'b0);
            3:
                r = crossing(1 << 22, 1 << 17, 1 << 14, 1'b0);
            4:
                r = crossing(1 << 20, 1 << 16, 3, 1'b1);
            default:
                r = crossing(1 << 30, 1 << 10, 1 << 4, 1'b0);
        endcase
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == REG_EPS)
            eps_reg = value;
        else
            gap_reg = value[GAP_W-1:0];
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || pair_ch.valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            pending_pairs.push_back(random_pair(int'($urandom_range(0, 7))));
        drain();
    endtask

    // sender
    always @(negedge clk)
    begin
        logic nv;
        if (rst_n)
        begin
            nv = pair_ch.valid;
            if (pair_ch.valid && pair_taken)
            begin
                expected_points.push_back(triangulate(pending_pairs[0]));
                void'(pending_pairs.pop_front());
                send_hold = draw_wait();
                nv = 1'b0;
            end
            if (!nv && pending_pairs.size() != 0)
            begin
                if (send_hold > 0)
                    send_hold--;
                else
                begin
                    nv = 1'b1;
                    pair_ch.first_origin_x  = pending_pairs[0][0];
                    pair_ch.first_origin_y  = pending_pairs[0][1];
                    pair_ch.first_origin_z  = pending_pairs[0][2];
                    pair_ch.first_dir_x     = pending_pairs[0][3];
                    pair_ch.first_dir_y     = pending_pairs[0][4];
                    pair_ch.first_dir_z     = pending_pairs[0][5];
                    pair_ch.second_origin_x = pending_pairs[0][6];
                    pair_ch.second_origin_y = pending_pairs[0][7];
                    pair_ch.second_origin_z = pending_pairs[0][8];
                    pair_ch.second_dir_x    = pending_pairs[0][9];
                    pair_ch.second_dir_y    = pending_pairs[0][10];
                    pair_ch.second_dir_z    = pending_pairs[0][11];
                end
            end
            pair_ch.valid = nv;
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (point_taken)
                recv_hold = draw_wait();
            if (recv_hold > 0)
            begin
                recv_hold--;
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        point_t want;
        pair_taken  <= pair_ch.valid && pair_ch.ready;
        point_taken <= res_ch.valid && res_ch.ready;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_points.size() == 0)
                report("unexpected transfer, status", res_ch.status, -1);
            else
            begin
                want = expected_points.pop_front();
                if (res_ch.point_x !== want.x) report("point_x", res_ch.point_x, want.x);
                if (res_ch.point_y !== want.y) report("point_y", res_ch.point_y, want.y);
                if (res_ch.point_z !== want.z) report("point_z", res_ch.point_z, want.z);
                if (res_ch.status !== want.st) report("status", res_ch.status, want.st);
            end
        end
    end

    initial
    begin
        pair_t p;
        mismatches  = 0;
        calm        = 1'b0;
        send_hold   = 0;
        recv_hold   = 0;
        pair_taken  = 1'b0;
        point_taken = 1'b0;
        eps_reg     = EPS_RESET;
        gap_reg     = GAP_RESET;
        rst_n       = 1'b0;
        pair_ch.valid = 1'b0;
        pair_ch.first_origin_x  = '0;
        pair_ch.first_origin_y  = '0;
        pair_ch.first_origin_z  = '0;
        pair_ch.first_dir_x     = '0;
        pair_ch.first_dir_y     = '0;
        pair_ch.first_dir_z     = '0;
        pair_ch.second_origin_x = '0;
        pair_ch.second_origin_y = '0;
        pair_ch.second_origin_z = '0;
        pair_ch.second_dir_x    = '0;
        pair_ch.second_dir_y    = '0;
        pair_ch.second_dir_z    = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_EPS;
        cfg_ch.data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero, extremes, axis lines, known crossings, parallel
        foreach (p[i]) p[i] = 0;
        pending_pairs.push_back(p);
        foreach (p[i]) p[i] = 32'sh7FFF_FFFF;
        pending_pairs.push_back(p);
        foreach (p[i]) p[i] = 32'sh8000_0000;
        pending_pairs.push_back(p);
        foreach (p[i]) p[i] = (i % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        pending_pairs.push_back(p);
        // x axis against a line along given y (z after exchange), offset half a unit in z
        p = '{0, 0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh8000, 0, 32'sh10000, 0};
        pending_pairs.push_back(p);
        p = '{0, 0, 0, 32'sh10000, 0, 0, 0, 0, 32'sh8000, 0, 0, 32'sh10000};
        pending_pairs.push_back(p);
        p = '{32'sh30000, 0, 0, 32'sh10000, 0, 0, 0, 32'sh20000, 0, 0, 32'sh10000, 0};
        pending_pairs.push_back(p);
        p = '{0, 0, 0, 32'sh10000, 0, 0, 32'sh5, 32'sh3, 0, 32'sh20000, 0, 0};
        pending_pairs.push_back(p);
        p = '{1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0};
        pending_pairs.push_back(p);
        p = '{-32'sh4000_0000, 0, 0, 1, 0, 0, 32'sh4000_0000, 0, 0, 0, 1, 0};
        pending_pairs.push_back(p);
        for (int i = 0; i < 8; i++)
            pending_pairs.push_back(random_pair(2 + (i % 4)));
        drain();

        calm = 1'b1;
        random_phase(60);
        calm = 1'b0;
        random_phase(100);

        cfg_write(REG_EPS, 32'd0);
        cfg_write(REG_GAP, 32'h7FFF_FFFF);
        random_phase(90);

        cfg_write(REG_EPS, 32'hFFFF_FFFF);
        cfg_write(REG_GAP, 32'd0);
        random_phase(50);

        for (int k = 0; k < 3; k++)
        begin
            cfg_write(REG_EPS, $urandom_range(0, 1 << 20));
            cfg_write(REG_GAP, $urandom_range(0, 1 << 24));
            calm = (k == 1);
            random_phase(60);
        end
        calm = 1'b0;

        if (expected_points.size() != 0)
            report("results left over", expected_points.size(), 0);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
